[design/leg_polar_kinematics_core_assert.svh]
// ----------------------------------------------------------------------------
// Leg polar kinematics assertion macros
// Shared concurrent assertion forms for the leg polar kinematics core.
// ----------------------------------------------------------------------------
`ifndef LEG_POLAR_KINEMATICS_CORE_ASSERT_SVH
`define LEG_POLAR_KINEMATICS_CORE_ASSERT_SVH

// same-cycle implication
`define LPK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpk same-cycle check failed");

// next-cycle implication
`define LPK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpk next-cycle check failed");

`endif

[design/lpk_pkg.sv]
// ----------------------------------------------------------------------------
// Leg polar kinematics package
// Types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lpk_pkg;

   localparam int XY_W = 32;
   localparam int Z_W  = 33;
   localparam int ZF_W = 34;

   localparam logic signed [ZF_W-1:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [ZF_W-1:0] Q30_HALF_PI = 34'sd1686629713;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic [15:0] LINK_LENGTH_RESET = 16'd16384;

   localparam int ATAN_ENTRIES = 24;

   typedef struct packed {
      logic signed [15:0] apos;
      logic signed [16:0] rdiff;
      logic signed [16:0] rsum;
      logic [1:0]         tag;
   } pass_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
      pass_type               pass;
   } cordic_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:  val = 33'sd843314857;
         1:  val = 33'sd497837829;
         2:  val = 33'sd263043837;
         3:  val = 33'sd133525159;
         4:  val = 33'sd67021687;
         5:  val = 33'sd33543516;
         6:  val = 33'sd16775851;
         7:  val = 33'sd8388437;
         8:  val = 33'sd4194283;
         9:  val = 33'sd2097149;
         10: val = 33'sd1048576;
         11: val = 33'sd524288;
         12: val = 33'sd262144;
         13: val = 33'sd131072;
         14: val = 33'sd65536;
         15: val = 33'sd32768;
         16: val = 33'sd16384;
         17: val = 33'sd8192;
         18: val = 33'sd4096;
         19: val = 33'sd2048;
         20: val = 33'sd1024;
         21: val = 33'sd512;
         22: val = 33'sd256;
         23: val = 33'sd128;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[design/lpk_channel_if.sv]
// ----------------------------------------------------------------------------
// Leg polar kinematics channels
// Valid/ready interfaces for the sample channel and the result channel.
// ----------------------------------------------------------------------------
interface lpk_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] motor_angle_a;
   logic signed [15:0] motor_angle_b;
   logic signed [15:0] motor_rate_a;
   logic signed [15:0] motor_rate_b;
   logic [1:0]         leg_tag;

   modport source (
      output valid, motor_angle_a, motor_angle_b, motor_rate_a, motor_rate_b, leg_tag,
      input  ready
   );
   modport sink (
      input  valid, motor_angle_a, motor_angle_b, motor_rate_a, motor_rate_b, leg_tag,
      output ready
   );
endinterface

interface lpk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] radial_position;
   logic signed [15:0] angular_position;
   logic signed [22:0] radial_velocity;
   logic signed [22:0] angular_velocity;
   logic [1:0]         leg_tag_out;

   modport source (
      output valid, radial_position, angular_position, radial_velocity,
             angular_velocity, leg_tag_out,
      input  ready
   );
   modport sink (
      input  valid, radial_position, angular_position, radial_velocity,
             angular_velocity, leg_tag_out,
      output ready
   );
endinterface

[design/lpk_entry.sv]
// ----------------------------------------------------------------------------
// Leg polar kinematics entry stage
// Forms the half-angle, folds it into the CORDIC range and seeds the vector.
// ----------------------------------------------------------------------------
`include "leg_polar_kinematics_core_assert.svh"

module lpk_entry (
   input  logic                clock,
   input  logic                reset,
   lpk_req_if.sink             req_chan,
   output logic                out_valid,
   input  logic                out_ready,
   output lpk_pkg::cordic_type out_data
);

   logic                valid_ff, valid_in;
   lpk_pkg::cordic_type data_ff, data_in;

   logic signed [16:0]             diff;
   logic signed [16:0]             asum;
   logic signed [lpk_pkg::ZF_W-1:0] z_raw;
   logic signed [lpk_pkg::ZF_W-1:0] z_fold;
   logic                           take;

   assign req_chan.ready = !valid_ff || out_ready;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      diff  = {req_chan.motor_angle_b[15], req_chan.motor_angle_b}
            - {req_chan.motor_angle_a[15], req_chan.motor_angle_a};
      asum  = {req_chan.motor_angle_a[15], req_chan.motor_angle_a}
            + {req_chan.motor_angle_b[15], req_chan.motor_angle_b};
      z_raw = {diff[16], diff, 16'b0};
      data_in.flip = 1'b1;
      if (z_raw > lpk_pkg::Q30_HALF_PI) begin
         z_fold = z_raw - lpk_pkg::Q30_PI;
      end else if (z_raw < -lpk_pkg::Q30_HALF_PI) begin
         z_fold = z_raw + lpk_pkg::Q30_PI;
      end else begin
         z_fold = z_raw;
         data_in.flip = 1'b0;
      end
      data_in.x = lpk_pkg::CORDIC_GAIN;
      data_in.y = '0;
      data_in.z = z_fold[lpk_pkg::Z_W-1:0];
      data_in.pass.apos  = asum[16:1];
      data_in.pass.rdiff = {req_chan.motor_rate_a[15], req_chan.motor_rate_a}
                         - {req_chan.motor_rate_b[15], req_chan.motor_rate_b};
      data_in.pass.rsum  = {req_chan.motor_rate_a[15], req_chan.motor_rate_a}
                         + {req_chan.motor_rate_b[15], req_chan.motor_rate_b};
      data_in.pass.tag   = req_chan.leg_tag;
      valid_in = take || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `LPK_ASSERT_NOW(a_fold_range, clock, reset, valid_ff,
      ($signed({data_ff.z[lpk_pkg::Z_W-1], data_ff.z}) <= lpk_pkg::Q30_HALF_PI &&
       $signed({data_ff.z[lpk_pkg::Z_W-1], data_ff.z}) >= -lpk_pkg::Q30_HALF_PI))

endmodule

[design/lpk_cordic_cell.sv]
// ----------------------------------------------------------------------------
// Leg polar kinematics CORDIC cell
// One registered rotation-mode micro-rotation with its own valid/ready slot.
// ----------------------------------------------------------------------------
`include "leg_polar_kinematics_core_assert.svh"

module lpk_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  lpk_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output lpk_pkg::cordic_type out_data
);

   localparam logic signed [lpk_pkg::Z_W-1:0] ATAN = lpk_pkg::atan_q30(STAGE);

   logic                valid_ff, valid_in;
   lpk_pkg::cordic_type data_ff, data_in;
   logic signed [lpk_pkg::XY_W-1:0] xs, ys;
   logic                take;

   assign in_ready = !valid_ff || out_ready;
   assign take = in_valid && in_ready;

   always_comb begin
      xs = in_data.x >>> STAGE;
      ys = in_data.y >>> STAGE;
      data_in = in_data;
      if (!in_data.z[lpk_pkg::Z_W-1]) begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ATAN;
      end else begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ATAN;
      end
      valid_in = take || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `LPK_ASSERT_NEXT(a_cell_hold, clock, reset, valid_ff && !out_ready,
      valid_ff && $stable(data_ff))

endmodule

[design/lpk_scale.sv]
// ----------------------------------------------------------------------------
// Leg polar kinematics scaling pipeline
// Applies the fold sign, scales by link length and rates, rounds and saturates.
// ----------------------------------------------------------------------------
`include "leg_polar_kinematics_core_assert.svh"

module lpk_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         link_length,
   input  logic                in_valid,
   output logic                in_ready,
   input  lpk_pkg::cordic_type in_data,
   lpk_rsp_if.source           rsp_chan
);

   localparam logic signed [49:0] RND_POS = 50'sd268435456;
   localparam logic signed [49:0] RND_L16 = 50'sd8192;
   localparam logic signed [53:0] RND_VEL = 54'sd33554432;
   localparam logic signed [20:0] POS_MAX = 21'sd131071;
   localparam logic signed [20:0] POS_MIN = -21'sd131072;
   localparam logic signed [27:0] VEL_MAX = 28'sd4194303;
   localparam logic signed [27:0] VEL_MIN = -28'sd4194304;

   // stage 1: link length products
   logic                  v1_ff, v1_in;
   logic signed [48:0]    pc_ff, pc_in, ps_ff, ps_in;
   lpk_pkg::pass_type     p1_ff;
   // stage 2: rounded position and 16-bit fraction terms
   logic                  v2_ff, v2_in;
   logic signed [17:0]    rpos2_ff, rpos2_in;
   logic signed [35:0]    lc_ff, lc_in, ls_ff, ls_in;
   lpk_pkg::pass_type     p2_ff;
   // stage 3: rate products
   logic                  v3_ff, v3_in;
   logic signed [52:0]    vr_ff, vr_in, va_ff, va_in;
   logic signed [17:0]    rpos3_ff;
   lpk_pkg::pass_type     p3_ff;
   // stage 4: result register
   logic                  v4_ff, v4_in;
   logic signed [17:0]    rpos4_ff;
   logic signed [15:0]    apos4_ff;
   logic signed [22:0]    rvel4_ff, rvel4_in, avel4_ff, avel4_in;
   logic [1:0]            tag4_ff;

   logic                  r1, r2, r3, r4;
   logic signed [lpk_pkg::XY_W-1:0] s_val, c_val;
   logic signed [16:0]    len_s;
   logic signed [49:0]    pc_ext, ps_ext;
   logic signed [49:0]    pos_sum, lc_sum, ls_sum;
   logic signed [20:0]    pos_wide;
   logic signed [53:0]    vr_sum, va_sum;
   logic signed [27:0]    vr_wide, va_wide;

   assign r4 = !v4_ff || rsp_chan.ready;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   always_comb begin
      s_val = in_data.flip ? -in_data.y : in_data.y;
      c_val = in_data.flip ? -in_data.x : in_data.x;
      len_s = $signed({1'b0, link_length});
      pc_in = len_s * c_val;
      ps_in = len_s * s_val;
      v1_in = (in_valid && r1) || (v1_ff && !r2);
   end

   always_comb begin
      pc_ext  = {pc_ff[48], pc_ff};
      ps_ext  = {ps_ff[48], ps_ff};
      pos_sum = pc_ext + RND_POS;
      lc_sum  = pc_ext + RND_L16;
      ls_sum  = ps_ext + RND_L16;
      pos_wide = pos_sum[49:29];
      if (pos_wide > POS_MAX) begin
         rpos2_in = POS_MAX[17:0];
      end else if (pos_wide < POS_MIN) begin
         rpos2_in = POS_MIN[17:0];
      end else begin
         rpos2_in = pos_wide[17:0];
      end
      lc_in = lc_sum[49:14];
      ls_in = ls_sum[49:14];
      v2_in = (v1_ff && r2) || (v2_ff && !r3);
   end

   always_comb begin
      vr_in = ls_ff * p2_ff.rdiff;
      va_in = lc_ff * p2_ff.rsum;
      v3_in = (v2_ff && r3) || (v3_ff && !r4);
   end

   always_comb begin
      vr_sum  = {vr_ff[52], vr_ff} + RND_VEL;
      va_sum  = {va_ff[52], va_ff} + RND_VEL;
      vr_wide = vr_sum[53:26];
      va_wide = va_sum[53:26];
      if (vr_wide > VEL_MAX) begin
         rvel4_in = VEL_MAX[22:0];
      end else if (vr_wide < VEL_MIN) begin
         rvel4_in = VEL_MIN[22:0];
      end else begin
         rvel4_in = vr_wide[22:0];
      end
      if (va_wide > VEL_MAX) begin
         avel4_in = VEL_MAX[22:0];
      end else if (va_wide < VEL_MIN) begin
         avel4_in = VEL_MIN[22:0];
      end else begin
         avel4_in = va_wide[22:0];
      end
      v4_in = (v3_ff && r4) || (v4_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && r1) begin
         pc_ff <= pc_in;
         ps_ff <= ps_in;
         p1_ff <= in_data.pass;
      end
      if (v1_ff && r2) begin
         rpos2_ff <= rpos2_in;
         lc_ff    <= lc_in;
         ls_ff    <= ls_in;
         p2_ff    <= p1_ff;
      end
      if (v2_ff && r3) begin
         vr_ff    <= vr_in;
         va_ff    <= va_in;
         rpos3_ff <= rpos2_ff;
         p3_ff    <= p2_ff;
      end
      if (v3_ff && r4) begin
         rpos4_ff <= rpos3_ff;
         apos4_ff <= p3_ff.apos;
         rvel4_ff <= rvel4_in;
         avel4_ff <= avel4_in;
         tag4_ff  <= p3_ff.tag;
      end
   end

   assign rsp_chan.valid            = v4_ff;
   assign rsp_chan.radial_position  = rpos4_ff;
   assign rsp_chan.angular_position = apos4_ff;
   assign rsp_chan.radial_velocity  = rvel4_ff;
   assign rsp_chan.angular_velocity = avel4_ff;
   assign rsp_chan.leg_tag_out      = tag4_ff;

   `LPK_ASSERT_NEXT(a_rate_stage_hold, clock, reset, v3_ff && !r4,
      v3_ff && $stable(vr_ff) && $stable(va_ff))

endmodule

[design/leg_polar_kinematics_core.sv]
// ----------------------------------------------------------------------------
// Leg polar kinematics core
// Motor angles and rates to polar foot position and velocity of a two-link leg.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the result channel does not stall and
// returns one result per sample, in order. The pipeline is one entry stage
// that folds the half-angle, one registered cell per CORDIC micro-rotation,
// and four scaling stages (link length products, rounding, rate products,
// rounding with saturation into the result register). Every stage has its
// own valid slot, so gaps close up and a stalled result blocks intake only
// once all stages are full. link_length resets to 16384. The user must write
// it via csr_wr_en only while no item is in flight; the core does not check.
module leg_polar_kinematics_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   lpk_req_if.sink     req_chan,
   lpk_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] link_length_ff;

   logic [CORDIC_STAGES:0] chain_valid;
   logic [CORDIC_STAGES:0] chain_ready;
   lpk_pkg::cordic_type    chain_data [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         link_length_ff <= lpk_pkg::LINK_LENGTH_RESET;
      end else if (csr_wr_en) begin
         link_length_ff <= csr_wr_data;
      end
   end

   lpk_entry u_entry (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      lpk_cordic_cell #(
         .STAGE (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   lpk_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .link_length (link_length_ff),
      .in_valid    (chain_valid[CORDIC_STAGES]),
      .in_ready    (chain_ready[CORDIC_STAGES]),
      .in_data     (chain_data[CORDIC_STAGES]),
      .rsp_chan    (rsp_chan)
   );

endmodule

[verif/leg_polar_checker.sv]
// ----------------------------------------------------------------------------
// Leg polar kinematics checker
// Watches the sample and result channels and the link-length port, predicts
// each result with an independent fixed-point CORDIC and compares it field by
// field with what the core returns, in order.
// ----------------------------------------------------------------------------
module leg_polar_checker #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   lpk_req_if          req_chan,
   lpk_rsp_if          rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [17:0] radial_position;
      logic signed [15:0] angular_position;
      logic signed [22:0] radial_velocity;
      logic signed [22:0] angular_velocity;
      logic [1:0]         leg_tag_out;
   } polar_state_type;

   localparam longint ROT_ANGLE [lpk_pkg::ATAN_ENTRIES] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128
   };

   logic [15:0]     link_length = lpk_pkg::LINK_LENGTH_RESET;
   polar_state_type expected_polar [$];

   function automatic longint round_half_up(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic polar_state_type foot_polar_state(
      input logic signed [15:0] angle_a,
      input logic signed [15:0] angle_b,
      input logic signed [15:0] rate_a,
      input logic signed [15:0] rate_b,
      input logic [1:0]         tag,
      input logic [15:0]        length_reg
   );
      longint          z, x, y, xs, ys, sin_h, cos_h, len, ls16, lc16;
      longint          rpos, apos, rvel, avel;
      bit              flip;
      polar_state_type r;
      len  = longint'(length_reg);
      z    = (longint'(angle_b) - longint'(angle_a)) * 65536;
      x    = longint'(lpk_pkg::CORDIC_GAIN);
      y    = 0;
      flip = 1'b0;
      if (z > longint'(lpk_pkg::Q30_HALF_PI)) begin
         z    = z - longint'(lpk_pkg::Q30_PI);
         flip = 1'b1;
      end else if (z < -longint'(lpk_pkg::Q30_HALF_PI)) begin
         z    = z + longint'(lpk_pkg::Q30_PI);
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < lpk_pkg::ATAN_ENTRIES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ROT_ANGLE[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ROT_ANGLE[i];
         end
      end
      sin_h = flip ? -y : y;
      cos_h = flip ? -x : x;
      rpos = clamp(round_half_up(2 * len * cos_h, 30), -131072, 131071);
      apos = (longint'(angle_a) + longint'(angle_b)) >>> 1;
      ls16 = round_half_up(len * sin_h, 14);
      lc16 = round_half_up(len * cos_h, 14);
      rvel = clamp(round_half_up(ls16 * (longint'(rate_a) - longint'(rate_b)), 26),
                   -4194304, 4194303);
      avel = clamp(round_half_up(lc16 * (longint'(rate_a) + longint'(rate_b)), 26),
                   -4194304, 4194303);
      r.radial_position  = rpos[17:0];
      r.angular_position = apos[15:0];
      r.radial_velocity  = rvel[22:0];
      r.angular_velocity = avel[22:0];
      r.leg_tag_out      = tag;
      return r;
   endfunction

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      polar_state_type want;
      if (reset) begin
         link_length = lpk_pkg::LINK_LENGTH_RESET;
         expected_polar.delete();
      end else begin
         if (csr_wr_en)
            link_length = csr_wr_data;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_polar.size() == 0) begin
               $error("result item with no sample outstanding");
               fail_count++;
            end else begin
               want = expected_polar.pop_front();
               compare_field("radial_position", want.radial_position,
                             rsp_chan.radial_position);
               compare_field("angular_position", want.angular_position,
                             rsp_chan.angular_position);
               compare_field("radial_velocity", want.radial_velocity,
                             rsp_chan.radial_velocity);
               compare_field("angular_velocity", want.angular_velocity,
                             rsp_chan.angular_velocity);
               compare_field("leg_tag_out", want.leg_tag_out, rsp_chan.leg_tag_out);
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_polar.push_back(foot_polar_state(
               req_chan.motor_angle_a, req_chan.motor_angle_b,
               req_chan.motor_rate_a, req_chan.motor_rate_b,
               req_chan.leg_tag, link_length));
      end
      pending = expected_polar.size();
   end

endmodule

[verif/tb_leg_polar_kinematics_core.sv]
// ----------------------------------------------------------------------------
// Leg polar kinematics core testbench
// Drives motor samples with random gaps and result back-pressure across
// several link lengths, directed corner samples first, then random ones;
// the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_leg_polar_kinematics_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     STAGES      = 16;
   localparam int     LATENCY     = STAGES + 5;
   localparam int     PHASE_ITEMS = 200;
   localparam longint RUN_LIMIT   = 600000;
   localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int          fail_count;
   int          pending;
   longint      cycle_count = 0;
   int          sent = 0;
   int          settings_used = 1;
   int          send_run = 0;
   int          take_run = 0;

   lpk_req_if req_chan ();
   lpk_rsp_if rsp_chan ();

   leg_polar_kinematics_core #(.CORDIC_STAGES(STAGES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   leg_polar_checker #(.CORDIC_STAGES(STAGES)) polar_check (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int draw_gap(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         run_left = $urandom_range(16, 64);
         return 0;
      end
      if ($urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic logic signed [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($urandom_range(0, 64)) - 16'sd32;
         default: return 16'($urandom());
      endcase
   endfunction

   // result side: hold ready low for a drawn gap, then high until an item is taken
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      forever begin
         gap = draw_gap(take_run);
         @(negedge clock);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   task automatic send_sample(
      input logic signed [15:0] angle_a,
      input logic signed [15:0] angle_b,
      input logic signed [15:0] rate_a,
      input logic signed [15:0] rate_b,
      input logic [1:0]         tag
   );
      int gap;
      gap = draw_gap(send_run);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.motor_angle_a <= angle_a;
      req_chan.motor_angle_b <= angle_b;
      req_chan.motor_rate_a  <= rate_a;
      req_chan.motor_rate_b  <= rate_b;
      req_chan.leg_tag       <= tag;
      req_chan.valid         <= 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_link_length(input logic [15:0] value);
      drain_results();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   task automatic send_corners();
      send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 2'd0);
      send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 2'd1);
      send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 2'd2);
      send_sample(16'sd0, 16'sd2 * HALF_PI_Q13 - 16'sd1, 16'sd1024, 16'sd0, 2'd3);
      send_sample(16'sd0, 16'sd2 * HALF_PI_Q13, 16'sh7FFF, 16'sh8000, 2'd0);
      send_sample(16'sd0, 16'sd2 * HALF_PI_Q13 + 16'sd1, 16'sh8000, 16'sh7FFF, 2'd1);
      send_sample(16'sd2 * HALF_PI_Q13, 16'sd0, 16'sh8000, 16'sh7FFF, 2'd2);
      send_sample(16'sd2 * HALF_PI_Q13 + 16'sd1, 16'sd0, 16'sh7FFF, 16'sh8000, 2'd3);
      send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 2'd3);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 2'd2);
      send_sample(-16'sd1, -16'sd2, -16'sd1, 16'sd1, 2'd1);
      send_sample(16'sd1, 16'sd0, 16'sd1, -16'sd1, 2'd0);
      send_sample(-16'sd1, -16'sd1, 16'sh8000, 16'sh8000, 2'd3);
      send_sample(16'sh4000, -16'sh4000, 16'sh7FFF, 16'sh7FFF, 2'd1);
   endtask

   task automatic send_random_sample();
      logic signed [15:0] angle_a, angle_b;
      angle_a = pick_word();
      case ($urandom_range(0, 4))
         0: angle_b = angle_a + 16'($urandom_range(0, 8)) - 16'sd4;
         1: angle_b = angle_a + 16'sd2 * HALF_PI_Q13 + 16'($urandom_range(0, 8)) - 16'sd4;
         2: angle_b = angle_a - 16'sd2 * HALF_PI_Q13 + 16'($urandom_range(0, 8)) - 16'sd4;
         default: angle_b = pick_word();
      endcase
      send_sample(angle_a, angle_b, pick_word(), pick_word(), 2'($urandom_range(0, 3)));
   endtask

   initial begin
      logic [15:0] length_value;
      req_chan.valid         <= 1'b0;
      req_chan.motor_angle_a <= '0;
      req_chan.motor_angle_b <= '0;
      req_chan.motor_rate_a  <= '0;
      req_chan.motor_rate_b  <= '0;
      req_chan.leg_tag       <= '0;
      csr_wr_en              <= 1'b0;
      csr_wr_data            <= '0;
      reset                  <= 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_corners();
      repeat (PHASE_ITEMS) send_random_sample();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: length_value = 16'hFFFF;
            1: length_value = 16'h0000;
            2: length_value = 16'h0001;
            3: length_value = 16'h8000;
            default: length_value = 16'($urandom());
         endcase
         write_link_length(length_value);
         if (phase == 0)
            send_corners();
         repeat (PHASE_ITEMS) send_random_sample();
      end

      drain_results();
      repeat (LATENCY + 10) @(negedge clock);

      $display("Ran %0d samples over %0d link-length settings, with half-angle folds,",
               sent, settings_used);
      $display("rate extremes and random gaps and back-pressure on both channels.");
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/lpk_pkg.sv
design/lpk_channel_if.sv
design/lpk_entry.sv
design/lpk_cordic_cell.sv
design/lpk_scale.sv
design/leg_polar_kinematics_core.sv
verif/leg_polar_checker.sv
verif/tb_leg_polar_kinematics_core.sv
